[rtl/core/awps_pkg.sv]
// ----------------------------------------------------------------------------
// awps_pkg
// Shared types and constants for the agent waypoint stepper: field widths,
// request codes, the stored waypoint record and the sequencer states.
// ----------------------------------------------------------------------------
package awps_pkg;

  // Field widths of the request and result payloads
  localparam int COORD_W = 16;
  localparam int RAD_W   = 15;

  // Request type codes
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // One waypoint as held in the ring memory
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [RAD_W-1:0]   r;
  } waypoint_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REACH_SQ,
    ST_REACH_CMP,
    ST_STEP_SQ,
    ST_STEP_CMP,
    ST_DONE
  } state_t;

  // Magnitude of a difference of two coordinates; always fits COORD_W bits
  function automatic logic [COORD_W-1:0] mag_of(input logic signed [COORD_W:0] d);
    logic signed [COORD_W:0] m;
    m = d[COORD_W] ? -d : d;
    return m[COORD_W-1:0];
  endfunction

endpackage

[rtl/core/awps_if.sv]
// ----------------------------------------------------------------------------
// awps_in_if / awps_out_if
// Valid/ready channels for the agent waypoint stepper: requests in, results
// out.
// ----------------------------------------------------------------------------
interface awps_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [awps_pkg::COORD_W-1:0] pos_x;
  logic signed [awps_pkg::COORD_W-1:0] pos_y;
  logic signed [awps_pkg::COORD_W-1:0] wp_x;
  logic signed [awps_pkg::COORD_W-1:0] wp_y;
  logic        [awps_pkg::RAD_W-1:0]   wp_radius;

  modport source (output valid, req_type, pos_x, pos_y, wp_x, wp_y, wp_radius,
                  input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, wp_x, wp_y, wp_radius,
                  output ready);
endinterface

interface awps_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [awps_pkg::COORD_W-1:0] desired_x;
  logic signed [awps_pkg::COORD_W-1:0] desired_y;
  logic                                has_target;
  logic signed [awps_pkg::COORD_W-1:0] target_x;
  logic signed [awps_pkg::COORD_W-1:0] target_y;
  logic        [awps_pkg::RAD_W-1:0]   target_radius;
  logic                                add_dropped;

  modport source (output valid, desired_x, desired_y, has_target, target_x,
                  target_y, target_radius, add_dropped, input ready);
  modport sink   (input valid, desired_x, desired_y, has_target, target_x,
                  target_y, target_radius, add_dropped, output ready);
endinterface

[rtl/core/agent_waypoint_step.sv]
// ----------------------------------------------------------------------------
// agent_waypoint_step
// Waypoint follower for one agent: a ring of waypoints in RAM, a current
// destination, and a one-cell step toward it on each tick request.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          req_type, pos_x/y, wp_x/y, wp_radius
//   out_ch   out  valid/ready          desired_x/y, has_target, target_x/y,
//                                      target_radius, add_dropped
//
// An add request goes from accept straight to the output load; a tick
// passes through the squaring of the distance, the arrival compare with
// ring rotation, squaring toward the new destination, the step compare and
// the output load. The ring RAM read is issued at the accept edge. One request
// is in flight at a time; the next is taken the cycle after the result is
// loaded into the output register. Reset is synchronous and clears the ring
// pointers, the destination and the desired position; ring contents are not
// cleared. A stalled result holds the block in its final state.
// ----------------------------------------------------------------------------
module agent_waypoint_step #(
  parameter int RING_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  awps_in_if.sink         in_ch,
  awps_out_if.source      out_ch
);

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CW    = awps_pkg::COORD_W;
  localparam int RW    = awps_pkg::RAD_W;

  awps_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]    head_r;
  logic [CNT_W-1:0]    count_r;
  logic                tgt_valid_r;
  awps_pkg::waypoint_t tgt_r;
  logic signed [CW-1:0] des_x_r, des_y_r;
  logic signed [CW-1:0] pos_x_r, pos_y_r;
  logic                drop_r;
  logic [2*CW-1:0]     sq_x_r, sq_y_r;
  logic [2*RW-1:0]     sq_r_r;

  logic                out_valid_r;
  logic signed [CW-1:0] out_des_x_r, out_des_y_r, out_tgt_x_r, out_tgt_y_r;
  logic                out_has_r, out_drop_r;
  logic [RW-1:0]       out_rad_r;

  // Sequencer strobes
  logic in_acc, do_add, do_rotate, ld_sq, ld_step, ld_out;

  // Ring memory port signals
  logic                ram_wr_en, ram_rd_en;
  logic [IDX_W-1:0]    ram_wr_addr;
  awps_pkg::waypoint_t ram_wr_data, ram_rd_data;

  logic                ring_full, reached;
  logic [SUM_W-1:0]    tail_sum, tail_wrap;
  logic [IDX_W-1:0]    tail_idx, head_inc;
  logic signed [CW:0]  dx, dy;
  logic [2*CW:0]       dist_sq;
  logic [2*CW+1:0]     sq_x3, sq_y3;
  logic signed [CW-1:0] step_x, step_y;

  // Ring pointer arithmetic
  assign ring_full = (count_r == CNT_W'(RING_DEPTH));
  assign tail_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_wrap = (tail_sum >= SUM_W'(RING_DEPTH)) ? tail_sum - SUM_W'(RING_DEPTH)
                                                      : tail_sum;
  assign tail_idx  = tail_wrap[IDX_W-1:0];
  assign head_inc  = (head_r == IDX_W'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;

  // Distance to the current destination
  assign dx = (CW+1)'(tgt_r.x) - (CW+1)'(pos_x_r);
  assign dy = (CW+1)'(tgt_r.y) - (CW+1)'(pos_y_r);

  // Arrival test and step decision on the registered squares
  assign dist_sq = (2*CW+1)'(sq_x_r) + (2*CW+1)'(sq_y_r);
  assign reached = tgt_valid_r && (dist_sq < (2*CW+1)'(sq_r_r));
  assign sq_x3   = (2*CW+2)'({sq_x_r, 1'b0}) + (2*CW+2)'(sq_x_r);
  assign sq_y3   = (2*CW+2)'({sq_y_r, 1'b0}) + (2*CW+2)'(sq_y_r);
  assign step_x  = (dx == '0 || sq_x3 <= (2*CW+2)'(sq_y_r)) ? '0 :
                   (dx[CW] ? '1 : CW'(1));
  assign step_y  = (dy == '0 || sq_y3 <= (2*CW+2)'(sq_x_r)) ? '0 :
                   (dy[CW] ? '1 : CW'(1));

  // Next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_acc    = 1'b0;
    do_add    = 1'b0;
    do_rotate = 1'b0;
    ld_sq     = 1'b0;
    ld_step   = 1'b0;
    ld_out    = 1'b0;
    unique case (state_r)
      awps_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          in_acc = 1'b1;
          if (in_ch.req_type == awps_pkg::REQ_TICK) begin
            state_nxt = awps_pkg::ST_REACH_SQ;
          end else begin
            do_add    = !ring_full;
            state_nxt = awps_pkg::ST_DONE;
          end
        end
      end
      awps_pkg::ST_REACH_SQ: begin
        ld_sq     = 1'b1;
        state_nxt = awps_pkg::ST_REACH_CMP;
      end
      awps_pkg::ST_REACH_CMP: begin
        do_rotate = (reached || !tgt_valid_r) && (count_r != '0);
        state_nxt = awps_pkg::ST_STEP_SQ;
      end
      awps_pkg::ST_STEP_SQ: begin
        ld_sq     = 1'b1;
        state_nxt = awps_pkg::ST_STEP_CMP;
      end
      awps_pkg::ST_STEP_CMP: begin
        ld_step   = 1'b1;
        state_nxt = awps_pkg::ST_DONE;
      end
      awps_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          ld_out    = 1'b1;
          state_nxt = awps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = awps_pkg::ST_IDLE;
    endcase
  end

  // Ring memory access: read the front on every accepted request, write on add
  // or when a reached destination goes to the back. The read is taken at the
  // accept edge; an add writes at that same edge but never uses the read data,
  // and a tick writes only in ST_REACH_CMP, so no forwarding is needed.
  assign ram_rd_en   = in_acc;
  assign ram_wr_en   = do_add || (do_rotate && tgt_valid_r);
  assign ram_wr_addr = tail_idx;
  always_comb begin
    if (do_add) begin
      ram_wr_data = '{x: in_ch.wp_x, y: in_ch.wp_y, r: in_ch.wp_radius};
    end else begin
      ram_wr_data = tgt_r;
    end
  end

  awps_ram #(
    .WIDTH ($bits(awps_pkg::waypoint_t)),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (head_r),
    .rd_data (ram_rd_data)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= awps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Ring pointers, destination and desired position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      tgt_valid_r <= 1'b0;
      tgt_r       <= '0;
      des_x_r     <= '0;
      des_y_r     <= '0;
      drop_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        drop_r <= (in_ch.req_type == awps_pkg::REQ_ADD) && ring_full;
      end
      if (do_add) begin
        count_r <= count_r + 1'b1;
      end
      if (do_rotate) begin
        tgt_r       <= ram_rd_data;
        tgt_valid_r <= 1'b1;
        head_r      <= head_inc;
        if (!tgt_valid_r) begin
          count_r <= count_r - 1'b1;
        end
      end
      if (ld_step && tgt_valid_r) begin
        des_x_r <= pos_x_r + step_x;
        des_y_r <= pos_y_r + step_y;
      end
    end
  end

  // Capture position and square the distances
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_x_r <= in_ch.pos_x;
      pos_y_r <= in_ch.pos_y;
    end
    if (ld_sq) begin
      sq_x_r <= (2*CW)'(awps_pkg::mag_of(dx)) * (2*CW)'(awps_pkg::mag_of(dx));
      sq_y_r <= (2*CW)'(awps_pkg::mag_of(dy)) * (2*CW)'(awps_pkg::mag_of(dy));
      sq_r_r <= (2*RW)'(tgt_r.r) * (2*RW)'(tgt_r.r);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_des_x_r <= des_x_r;
      out_des_y_r <= des_y_r;
      out_has_r   <= tgt_valid_r;
      out_tgt_x_r <= tgt_valid_r ? tgt_r.x : '0;
      out_tgt_y_r <= tgt_valid_r ? tgt_r.y : '0;
      out_rad_r   <= tgt_valid_r ? tgt_r.r : '0;
      out_drop_r  <= drop_r;
    end
  end

  assign in_ch.ready          = (state_r == awps_pkg::ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.desired_x     = out_des_x_r;
  assign out_ch.desired_y     = out_des_y_r;
  assign out_ch.has_target    = out_has_r;
  assign out_ch.target_x      = out_tgt_x_r;
  assign out_ch.target_y      = out_tgt_y_r;
  assign out_ch.target_radius = out_rad_r;
  assign out_ch.add_dropped   = out_drop_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RING_DEPTH))
    else $error("ring count beyond depth");

  a_tgt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(tgt_valid_r))
    else $error("destination lost");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == awps_pkg::ST_DONE && drop_r) |-> ring_full)
    else $error("add dropped with room in ring");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    ld_out |=> (out_valid_r && state_r == awps_pkg::ST_IDLE))
    else $error("result load out of sequence");

endmodule

[rtl/core/awps_ram.sv]
// ----------------------------------------------------------------------------
// awps_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module awps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[tb/tb_agent_waypoint_step.sv]
// ----------------------------------------------------------------------------
// tb_agent_waypoint_step
// Self-checking bench for the agent waypoint stepper. Add and tick requests
// go in over the request channel, in random bursts. A scoreboard class keeps
// its own copy of the ring, the destination and the desired position. For
// each accepted request it predicts the result, and it compares every
// returned result with that prediction field by field. The result channel
// stalls on a pattern that changes from stretch to stretch.
// ----------------------------------------------------------------------------
module tb_agent_waypoint_step;
  timeunit 1ns;
  timeprecision 1ps;

  import awps_pkg::*;

  localparam int RING_DEPTH = 16;

  typedef struct {
    logic                      req_type;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] wp_x;
    logic signed [COORD_W-1:0] wp_y;
    logic        [RAD_W-1:0]   wp_radius;
  } request_t;

  typedef struct {
    logic signed [COORD_W-1:0] desired_x;
    logic signed [COORD_W-1:0] desired_y;
    logic                      has_target;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic        [RAD_W-1:0]   target_radius;
    logic                      add_dropped;
  } result_t;

  // Waypoint-following scoreboard: predicted state plus queue of expected results
  class waypoint_follow_board;
    waypoint_t                 ring [RING_DEPTH];
    int unsigned               head;
    int unsigned               count;
    bit                        tgt_valid;
    waypoint_t                 tgt;
    logic signed [COORD_W-1:0] des_x;
    logic signed [COORD_W-1:0] des_y;
    result_t                   expected_steps [$];
    int                        errors;

    function new();
      head      = 0;
      count     = 0;
      tgt_valid = 0;
      tgt       = '0;
      des_x     = '0;
      des_y     = '0;
      errors    = 0;
    endfunction

    // One-cell move along one axis: sign(d) when 3*d^2 > o^2
    function longint step_toward(longint d, longint o);
      if (d == 0) return 0;
      if (3 * d * d > o * o) return (d > 0) ? 1 : -1;
      return 0;
    endfunction

    // Advance the predicted state by one accepted request; queue its result
    function void note_request(request_t rq);
      result_t   res;
      longint    dx;
      longint    dy;
      bit        reached;
      waypoint_t nxt;
      res.add_dropped = 1'b0;
      if (rq.req_type == REQ_ADD) begin
        if (count >= RING_DEPTH) begin
          res.add_dropped = 1'b1;
        end else begin
          ring[(head + count) % RING_DEPTH] = '{x: rq.wp_x, y: rq.wp_y, r: rq.wp_radius};
          count++;
        end
      end else begin
        reached = 1'b0;
        if (tgt_valid) begin
          dx = longint'(tgt.x) - longint'(rq.pos_x);
          dy = longint'(tgt.y) - longint'(rq.pos_y);
          reached = (dx * dx + dy * dy) < (longint'(tgt.r) * longint'(tgt.r));
        end
        // Rotate the ring on arrival, or take the front when no destination yet
        if ((reached || !tgt_valid) && count > 0) begin
          nxt = ring[head];
          if (tgt_valid) ring[(head + count) % RING_DEPTH] = tgt;
          else count--;
          head      = (head + 1) % RING_DEPTH;
          tgt       = nxt;
          tgt_valid = 1'b1;
        end
        if (tgt_valid) begin
          dx    = longint'(tgt.x) - longint'(rq.pos_x);
          dy    = longint'(tgt.y) - longint'(rq.pos_y);
          des_x = COORD_W'(longint'(rq.pos_x) + step_toward(dx, dy));
          des_y = COORD_W'(longint'(rq.pos_y) + step_toward(dy, dx));
        end
      end
      res.desired_x     = des_x;
      res.desired_y     = des_y;
      res.has_target    = tgt_valid;
      res.target_x      = tgt_valid ? tgt.x : '0;
      res.target_y      = tgt_valid ? tgt.y : '0;
      res.target_radius = tgt_valid ? tgt.r : '0;
      expected_steps = {expected_steps, res};
    endfunction

    function void cmp_field(string name, logic signed [COORD_W:0] want,
                            logic signed [COORD_W:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare one returned result against the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (expected_steps.size() == 0) begin
        errors++;
        $display("%0t: result with no pending request: expected none, actual %p",
                 $time, got);
        return;
      end
      want = expected_steps[0];
      expected_steps.delete(0);
      cmp_field("desired_x",     want.desired_x,     got.desired_x);
      cmp_field("desired_y",     want.desired_y,     got.desired_y);
      cmp_field("has_target",    want.has_target,    got.has_target);
      cmp_field("target_x",      want.target_x,      got.target_x);
      cmp_field("target_y",      want.target_y,      got.target_y);
      cmp_field("target_radius", want.target_radius, got.target_radius);
      cmp_field("add_dropped",   want.add_dropped,   got.add_dropped);
    endfunction

    function int pending();
      return expected_steps.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  awps_in_if  in_ch ();
  awps_out_if out_ch ();

  agent_waypoint_step #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  waypoint_follow_board sb;
  int                   burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("agent_waypoint_step test failed");
    $finish;
  end

  function automatic logic signed [COORD_W-1:0] clamp16(longint v);
    if (v > 32767) return COORD_W'(32767);
    if (v < -32768) return COORD_W'(-32768);
    return COORD_W'(v);
  endfunction

  function automatic request_t fill_request(logic kind);
    request_t rq;
    rq.req_type  = kind;
    rq.pos_x     = COORD_W'($urandom);
    rq.pos_y     = COORD_W'($urandom);
    rq.wp_x      = COORD_W'($urandom);
    rq.wp_y      = COORD_W'($urandom);
    rq.wp_radius = RAD_W'($urandom);
    return rq;
  endfunction

  function automatic request_t add_req(longint x, longint y, longint r);
    request_t rq;
    rq           = fill_request(REQ_ADD);
    rq.wp_x      = COORD_W'(x);
    rq.wp_y      = COORD_W'(y);
    rq.wp_radius = RAD_W'(r);
    return rq;
  endfunction

  function automatic request_t tick_req(longint x, longint y);
    request_t rq;
    rq       = fill_request(REQ_TICK);
    rq.pos_x = COORD_W'(x);
    rq.pos_y = COORD_W'(y);
    return rq;
  endfunction

  // Random request: mostly waypoints near the origin and ticks near the
  // destination or along the agent's own path, so the ring keeps rotating
  function automatic request_t random_request();
    request_t rq;
    int       sel;
    int       span;
    if (sb.count >= RING_DEPTH)
      rq = fill_request(($urandom_range(0, 5) == 0) ? REQ_ADD : REQ_TICK);
    else
      rq = fill_request(($urandom_range(0, 99) < 35) ? REQ_ADD : REQ_TICK);
    if (rq.req_type == REQ_ADD) begin
      if ($urandom_range(0, 4) != 0) begin
        rq.wp_x      = COORD_W'(int'($urandom_range(0, 120)) - 60);
        rq.wp_y      = COORD_W'(int'($urandom_range(0, 120)) - 60);
        rq.wp_radius = RAD_W'($urandom_range(1, 20));
      end
      // A zero-radius destination is never reached and would freeze the ring
      if (rq.wp_radius == 0 && sb.count < RING_DEPTH) rq.wp_radius = 1;
    end else begin
      sel = $urandom_range(0, 9);
      if (sel < 4 && sb.tgt_valid) begin
        span     = (sb.tgt.r > 40) ? 40 : int'(sb.tgt.r) + 1;
        rq.pos_x = clamp16(longint'(sb.tgt.x) + int'($urandom_range(0, 2 * span)) - span);
        rq.pos_y = clamp16(longint'(sb.tgt.y) + int'($urandom_range(0, 2 * span)) - span);
      end else if (sel < 7) begin
        rq.pos_x = sb.des_x;
        rq.pos_y = sb.des_y;
      end
    end
    return rq;
  endfunction

  // Present one request, hold it until accepted, then idle between bursts
  task automatic issue(input request_t rq);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= rq.req_type;
    in_ch.pos_x     <= rq.pos_x;
    in_ch.pos_y     <= rq.pos_y;
    in_ch.wp_x      <= rq.wp_x;
    in_ch.wp_y      <= rq.wp_y;
    in_ch.wp_radius <= rq.wp_radius;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(rq);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every outstanding result has returned
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    int k;
    // Ticks with an empty ring keep the desired position
    issue(tick_req(0, 0));
    issue(tick_req(-32768, 32767));
    // Fill the ring, extremes first
    issue(add_req(32767, -32768, 32767));
    issue(add_req(-32768, 32767, 1));
    issue(add_req(0, 0, 1));
    for (k = 3; k < RING_DEPTH; k++)
      issue(add_req(int'($urandom_range(0, 200)) - 100,
                    int'($urandom_range(0, 200)) - 100, $urandom_range(1, 30)));
    // Add on a full ring is dropped
    issue(add_req(-1, -1, 0));
    // First destination taken from the ring; zero distance gives no move
    issue(tick_req(32767, -32768));
    // Far away, outside the radius: diagonal step
    issue(tick_req(-32768, 32767));
    // Arrival: rotate, old destination goes to the back of the ring
    issue(tick_req(32767, -32768));
    // Exactly on a radius-1 destination: arrival again
    issue(tick_req(-32768, 32767));
    issue(tick_req(5, -3));
  endtask

  // Result receiver: ready pattern changes every stretch
  initial begin
    int mode;
    int len;
    int cyc;
    out_ch.ready <= 1'b0;
    cyc = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 150);
      repeat (len) begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= ($urandom_range(0, 7) == 0);
          default: out_ch.ready <= (cyc % 5 != 0);
        endcase
        cyc++;
        @(posedge clk);
      end
    end
  end

  // Capture each accepted result
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.desired_x     = out_ch.desired_x;
      got.desired_y     = out_ch.desired_y;
      got.has_target    = out_ch.has_target;
      got.target_x      = out_ch.target_x;
      got.target_y      = out_ch.target_y;
      got.target_radius = out_ch.target_radius;
      got.add_dropped   = out_ch.add_dropped;
      sb.check_result(got);
    end
  end

  // Reset, directed requests, random requests, final drain
  initial begin
    int n;
    sb              = new();
    burst_left      = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= REQ_ADD;
    in_ch.pos_x     <= '0;
    in_ch.pos_y     <= '0;
    in_ch.wp_x      <= '0;
    in_ch.wp_y      <= '0;
    in_ch.wp_radius <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    drain();
    for (n = 0; n < 1050; n++) begin
      issue(random_request());
      if (n % 300 == 299) drain();
    end
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("agent_waypoint_step test passed");
    else
      $display("agent_waypoint_step test failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/awps_pkg.sv
rtl/core/awps_if.sv
rtl/core/awps_ram.sv
rtl/core/agent_waypoint_step.sv
tb/tb_agent_waypoint_step.sv
